FILE: design/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int QTE_CORDIC_STAGES = 16;
  localparam int QTE_FRAC_BITS     = 14;
  localparam int QTE_ANGLE_W       = 32;
  localparam logic signed [15:0] QTE_QUARTER_TURN = 16'sd16384;

  // per-item flags that travel beside the CORDIC chains
  typedef struct packed {
    logic zero_roll;
    logic zero_yaw;
    logic clamp;
    logic neg;
  } qte_flags_t;

  // atan(2^-i) as a binary angle, 2^31 = pi
  function automatic logic [QTE_ANGLE_W-1:0] atan_entry(input int idx);
    logic [QTE_ANGLE_W-1:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/quaternion_to_euler_xyz.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_xyz
// Unit quaternion to roll, pitch, yaw binary angles, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  dir  tdata fields (low bit up)                   width
//  s_*      in   quat_w, quat_x, quat_y, quat_z               64
//  m_*      out  roll_angle, pitch_angle, yaw_angle,          56
//                pitch_clamped, zero fill
//
//  One beat per cycle while m_* is not stalled. The pipe holds two registers
//  for products and terms, one for the pitch radicand, FRAC_BITS+1 square
//  root cells, CORDIC_STAGES rotation cells and the output register.
//  Reset clears only the valid bits. A stall on m_* freezes every stage.
// ----------------------------------------------------------------------------
module quaternion_to_euler_xyz import qte_pkg::*; #(
  parameter int CORDIC_STAGES = QTE_CORDIC_STAGES,
  parameter int FRAC_BITS     = QTE_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // roll_angle, pitch_angle, yaw_angle, pitch_clamped
);

  localparam int TW = FRAC_BITS + 2;
  localparam int N  = FRAC_BITS + 1;
  localparam int RW = 2 * N;
  localparam int W  = FRAC_BITS + 4;
  localparam int S  = CORDIC_STAGES;
  localparam int LV = N + S + 3;
  localparam logic signed [TW-1:0] UNIT = TW'(1) <<< FRAC_BITS;
  localparam logic [RW-1:0] ONE2R = RW'(1) << (2 * FRAC_BITS);
  localparam logic [QTE_ANGLE_W-1:0] HALF_TURN = 32'h80000000;
  localparam logic [QTE_ANGLE_W-1:0] ROUND_LSB = 32'h00008000;

  logic en;
  logic vld [LV];

  logic signed [TW-1:0] t_sr, t_cr, t_sp, t_sy, t_cy;
  logic signed [2*TW-1:0] sp_sq;

  logic signed [TW-1:0] d_sr [N+1];
  logic signed [TW-1:0] d_cr [N+1];
  logic signed [TW-1:0] d_sp [N+1];
  logic signed [TW-1:0] d_sy [N+1];
  logic signed [TW-1:0] d_cy [N+1];
  logic                 d_cl [N+1];
  logic [RW-1:0]  q_rad  [N+1];
  logic [N+1:0]   q_rem  [N+1];
  logic [N-1:0]   q_root [N+1];

  logic signed [W-1:0]    cx [3][S+1];
  logic signed [W-1:0]    cy [3][S+1];
  logic [QTE_ANGLE_W-1:0] cz [3][S+1];
  qte_flags_t flg_in;
  qte_flags_t flg [S];

  logic signed [W-1:0] rx_raw, ry_raw, yx_raw, yy_raw;
  logic [QTE_ANGLE_W-1:0] z_roll, z_pitch, z_yaw;
  logic signed [15:0] a_roll, a_pitch, a_yaw, p_out;

  // advance the whole pipe unless the output beat is held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LV; i++) vld[i] <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < LV; i++) vld[i] <= vld[i-1];
      m_tvalid <= vld[LV-1];
    end
  end

  qte_terms #(.FRAC_BITS(FRAC_BITS)) u_terms (
    .clk(clk), .en(en),
    .quat_w(s_tdata[15:0]), .quat_x(s_tdata[31:16]),
    .quat_y(s_tdata[47:32]), .quat_z(s_tdata[63:48]),
    .sr(t_sr), .cr(t_cr), .sp(t_sp), .sy(t_sy), .cy(t_cy)
  );

  assign sp_sq = t_sp * t_sp;

  // pitch radicand and clamp detect, hold the other terms beside the root cells
  always_ff @(posedge clk) begin
    if (en) begin
      d_sr[0] <= t_sr;
      d_cr[0] <= t_cr;
      d_sp[0] <= t_sp;
      d_sy[0] <= t_sy;
      d_cy[0] <= t_cy;
      if (t_sp >= UNIT || t_sp <= -UNIT) begin
        d_cl[0]  <= 1'b1;
        q_rad[0] <= '0;
      end else begin
        d_cl[0]  <= 1'b0;
        q_rad[0] <= ONE2R - sp_sq[RW-1:0];
      end
      for (int i = 1; i <= N; i++) begin
        d_sr[i] <= d_sr[i-1];
        d_cr[i] <= d_cr[i-1];
        d_sp[i] <= d_sp[i-1];
        d_sy[i] <= d_sy[i-1];
        d_cy[i] <= d_cy[i-1];
        d_cl[i] <= d_cl[i-1];
      end
    end
  end

  assign q_rem[0]  = '0;
  assign q_root[0] = '0;

  for (genvar j = 0; j < N; j++) begin : g_sqrt
    qte_sqrt_cell #(.ROOT_W(N)) u_cell (
      .clk(clk), .en(en),
      .rad_in(q_rad[j]), .rem_in(q_rem[j]), .root_in(q_root[j]),
      .rad_out(q_rad[j+1]), .rem_out(q_rem[j+1]), .root_out(q_root[j+1])
    );
  end

  // fold left half plane into the right, seed the angles
  assign rx_raw = W'(d_cr[N]);
  assign ry_raw = W'(d_sr[N]);
  assign yx_raw = W'(d_cy[N]);
  assign yy_raw = W'(d_sy[N]);

  always_comb begin
    cx[0][0] = rx_raw[W-1] ? -rx_raw : rx_raw;
    cy[0][0] = rx_raw[W-1] ? -ry_raw : ry_raw;
    cz[0][0] = rx_raw[W-1] ? HALF_TURN : '0;
    cx[1][0] = W'({1'b0, q_root[N]});
    cy[1][0] = W'(d_sp[N]);
    cz[1][0] = '0;
    cx[2][0] = yx_raw[W-1] ? -yx_raw : yx_raw;
    cy[2][0] = yx_raw[W-1] ? -yy_raw : yy_raw;
    cz[2][0] = yx_raw[W-1] ? HALF_TURN : '0;
    flg_in.zero_roll = (rx_raw == '0) && (ry_raw == '0);
    flg_in.zero_yaw  = (yx_raw == '0) && (yy_raw == '0);
    flg_in.clamp     = d_cl[N];
    flg_in.neg       = d_sp[N][TW-1];
  end

  for (genvar c = 0; c < 3; c++) begin : g_chain
    for (genvar i = 0; i < S; i++) begin : g_cell
      qte_cordic_cell #(.W(W), .STAGE(i)) u_cell (
        .clk(clk), .en(en),
        .x_in(cx[c][i]), .y_in(cy[c][i]), .z_in(cz[c][i]),
        .x_out(cx[c][i+1]), .y_out(cy[c][i+1]), .z_out(cz[c][i+1])
      );
    end
  end

  // carry flags along the rotation cells
  always_ff @(posedge clk) begin
    if (en) begin
      flg[0] <= flg_in;
      for (int i = 1; i < S; i++) flg[i] <= flg[i-1];
    end
  end

  // round accumulators to 16-bit binary angles
  assign z_roll  = cz[0][S] + ROUND_LSB;
  assign z_pitch = cz[1][S] + ROUND_LSB;
  assign z_yaw   = cz[2][S] + ROUND_LSB;
  assign a_roll  = flg[S-1].zero_roll ? 16'sd0 : z_roll[31:16];
  assign a_yaw   = flg[S-1].zero_yaw  ? 16'sd0 : z_yaw[31:16];
  assign a_pitch = z_pitch[31:16];

  always_comb begin
    if (flg[S-1].clamp)                p_out = flg[S-1].neg ? -QTE_QUARTER_TURN : QTE_QUARTER_TURN;
    else if (a_pitch > QTE_QUARTER_TURN)  p_out = QTE_QUARTER_TURN;
    else if (a_pitch < -QTE_QUARTER_TURN) p_out = -QTE_QUARTER_TURN;
    else                               p_out = a_pitch;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {7'b0, flg[S-1].clamp, a_yaw, p_out, a_roll};
    end
  end

endmodule

FILE: design/qte_terms.sv
// ----------------------------------------------------------------------------
// qte_terms
// Two-stage front end: quaternion products, then the five rounded trig terms.
// ----------------------------------------------------------------------------
module qte_terms import qte_pkg::*; #(
  parameter int FRAC_BITS = QTE_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [15:0]            quat_w,
  input  logic signed [15:0]            quat_x,
  input  logic signed [15:0]            quat_y,
  input  logic signed [15:0]            quat_z,
  output logic signed [FRAC_BITS+1:0]   sr,
  output logic signed [FRAC_BITS+1:0]   cr,
  output logic signed [FRAC_BITS+1:0]   sp,
  output logic signed [FRAC_BITS+1:0]   sy,
  output logic signed [FRAC_BITS+1:0]   cy
);

  localparam int TW = FRAC_BITS + 2;
  localparam int SW = (2 * FRAC_BITS + 4 > 36) ? 2 * FRAC_BITS + 4 : 36;
  localparam logic signed [SW-1:0] ONE2 = SW'(1) <<< (2 * FRAC_BITS);
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] LIM  = SW'(1) <<< (FRAC_BITS + 1);

  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;

  // round half up, saturate to Q2.F
  function automatic logic signed [TW-1:0] round_term(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    logic signed [TW-1:0] r;
    t = (v + HALF) >>> FRAC_BITS;
    if (t > LIM - SW'(1)) r = {1'b0, {(TW-1){1'b1}}};
    else if (t < -LIM)    r = {1'b1, {(TW-1){1'b0}}};
    else                  r = t[TW-1:0];
    return r;
  endfunction

  // register products
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= quat_w * quat_x;
      p_yz <= quat_y * quat_z;
      p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y;
      p_wy <= quat_w * quat_y;
      p_zx <= quat_z * quat_x;
      p_wz <= quat_w * quat_z;
      p_xy <= quat_x * quat_y;
      p_zz <= quat_z * quat_z;
    end
  end

  // form and round terms
  always_ff @(posedge clk) begin
    if (en) begin
      sr <= round_term((SW'(p_wx) + SW'(p_yz)) <<< 1);
      cr <= round_term(ONE2 - ((SW'(p_xx) + SW'(p_yy)) <<< 1));
      sp <= round_term((SW'(p_wy) - SW'(p_zx)) <<< 1);
      sy <= round_term((SW'(p_wz) + SW'(p_xy)) <<< 1);
      cy <= round_term(ONE2 - ((SW'(p_yy) + SW'(p_zz)) <<< 1));
    end
  end

endmodule

FILE: design/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One root digit of a pipelined restoring integer square root.
// ----------------------------------------------------------------------------
module qte_sqrt_cell import qte_pkg::*; #(
  parameter int ROOT_W = QTE_FRAC_BITS + 1
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [2*ROOT_W-1:0]     rad_in,
  input  logic [ROOT_W+1:0]       rem_in,
  input  logic [ROOT_W-1:0]       root_in,
  output logic [2*ROOT_W-1:0]     rad_out,
  output logic [ROOT_W+1:0]       rem_out,
  output logic [ROOT_W-1:0]       root_out
);

  logic [ROOT_W+3:0] rem_sh;
  logic [ROOT_W+3:0] trial;
  logic              take;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
    trial  = {2'b00, root_in, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= rad_in << 2;
      rem_out  <= take ? (ROOT_W+2)'(rem_sh - trial) : rem_sh[ROOT_W+1:0];
      root_out <= {root_in[ROOT_W-2:0], take};
    end
  end

endmodule

FILE: design/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring CORDIC micro-rotation with a registered result.
// ----------------------------------------------------------------------------
module qte_cordic_cell import qte_pkg::*; #(
  parameter int W     = QTE_FRAC_BITS + 4,
  parameter int STAGE = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [W-1:0]     x_in,
  input  logic signed [W-1:0]     y_in,
  input  logic [QTE_ANGLE_W-1:0]  z_in,
  output logic signed [W-1:0]     x_out,
  output logic signed [W-1:0]     y_out,
  output logic [QTE_ANGLE_W-1:0]  z_out
);

  localparam logic [QTE_ANGLE_W-1:0] ATAN = atan_entry(STAGE);

  logic signed [W-1:0] dx, dy;

  assign dx = y_in >>> STAGE;
  assign dy = x_in >>> STAGE;

  // rotate toward the x axis
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[W-1]) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ATAN;
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ATAN;
      end
    end
  end

endmodule
